>>> hw/rtl/pfm_pkg.sv
package pfm_pkg;

  localparam int unsigned MaxSamples  = 8192;
  localparam int unsigned NumChannels = 120;
  localparam int unsigned AdcBits     = 14;
  localparam int unsigned SumW        = 21;
  localparam int unsigned TickW       = 13;
  localparam int unsigned ChanW       = 7;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CfgIdxW-1:0] RegWinStart  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWinLen    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPrelimLen = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPromptLen = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBaseline  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegGain      = 3'd6;
  localparam logic [CfgIdxW-1:0] RegEnables   = 3'd7;

  // pe = floor(diff * gain / 4096), saturated to 32 bits signed
  function automatic logic [31:0] pe_sat(input logic signed [47:0] prod);
    logic signed [47:0] sh;
    sh = prod >>> 12;
    if (sh > 48'sd2147483647) pe_sat = 32'h7fffffff;
    else if (sh < -48'sd2147483648) pe_sat = 32'h80000000;
    else pe_sat = sh[31:0];
  endfunction

endpackage

>>> hw/rtl/pfm_ram.sv
module pfm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/pmt_flash_metrics.sv
// Flash metrics over one event of PMT samples. A sample beat is taken per cycle
// while in the run state: each in-range one read-modify-writes one tick-sum entry
// and one channel entry, and a sample that hits the entry written by the beat just
// before it takes that value from a one-stage forwarding register. On the
// end-of-event beat the block stops accepting and, after the last write-back, runs
// a pass: over the channels, then over the whole sum store, clearing each entry
// and finding the flash minima among ticks 0..last, then the PE product steps and
// a step to build the result. The result beat is then offered, and input stays
// held off until it is taken. After reset a clearing pass over the whole sum store
// runs before the first beat is taken.
module pmt_flash_metrics
  import pfm_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = pfm_pkg::NumChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // channel[6:0], sample_index[19:7], adc_value[33:20], zero fill
  input  logic [39:0]         s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // hit_channels[6:0], prompt_pe[38:7], prelim_pe[70:39], peak_pe[102:71],
  // peak_tick[116:103], count_valid[117], pe_valid[118], flash_valid[119]
  output logic [119:0]        m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxSamples);
  localparam int unsigned CW = $clog2(NUM_CHANNELS) > 0 ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CE = 2 * AdcBits + TickW + 1; // prelim, prompt, hit, hit tick
  localparam logic [SumW-1:0] SumMax = '1;
  localparam logic [AdcBits-1:0] AdcMax = '1;

  typedef enum logic [6:0] {
    StClr  = 7'b0000001,
    StRun  = 7'b0000010,
    StChan = 7'b0000100,
    StTick = 7'b0001000,
    StMul  = 7'b0010000,
    StAcc  = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [12:0] start_q, wlen_q, plen_q, qlen_q;
  logic [13:0] thr_q, base_q;
  logic [15:0] gain_q;
  logic [2:0]  en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 13'd1000; wlen_q <= 13'd900; plen_q <= 13'd250; qlen_q <= 13'd50;
      thr_q <= 14'd14200; base_q <= 14'd14250; gain_q <= 16'd5243; en_q <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWinStart:  start_q <= cfg_data_i[12:0];
        RegWinLen:    wlen_q  <= cfg_data_i[12:0];
        RegPrelimLen: plen_q  <= cfg_data_i[12:0];
        RegPromptLen: qlen_q  <= cfg_data_i[12:0];
        RegThreshold: thr_q   <= cfg_data_i[13:0];
        RegBaseline:  base_q  <= cfg_data_i[13:0];
        RegGain:      gain_q  <= cfg_data_i[15:0];
        RegEnables:   en_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [13:0] pstart, wend14, qend14;
  assign pstart = (start_q > plen_q) ? {1'b0, start_q - plen_q} : 14'd0;
  assign qend14 = {1'b0, start_q} + {1'b0, qlen_q};
  assign wend14 = {1'b0, start_q} + {1'b0, wlen_q};

  // input decode
  logic [ChanW-1:0]   in_ch;
  logic [TickW-1:0]   in_tk;
  logic [AdcBits-1:0] in_adc;
  logic               in_ok, acc;
  logic               e1_q;
  assign in_ch  = s_axis_tdata[6:0];
  assign in_tk  = s_axis_tdata[19:7];
  assign in_adc = s_axis_tdata[33:20];
  assign in_ok  = ({25'd0, in_ch} < NUM_CHANNELS) && ({19'd0, in_tk} < MaxSamples);
  assign s_axis_tready = (state_q == StRun) && !e1_q;
  assign acc = s_axis_tvalid && s_axis_tready;

  // stage 1 (read issued) registers
  logic             v1_q;
  logic [AW-1:0]    tk1_q;
  logic [CW-1:0]    ch1_q;
  logic [AdcBits-1:0] adc1_q;
  logic             inpre1_q, inpro1_q, hit1_q;
  logic [TickW-1:0] tkf1_q;

  // seen flags and last tick
  logic [NUM_CHANNELS-1:0] seen_q;
  logic [TickW-1:0]        last_q;

  // memories
  logic [SumW-1:0] sum_rd, sum_wd;
  logic [AW-1:0]   sum_ra, sum_wa;
  logic            sum_we;
  logic [CE-1:0]   ch_rd, ch_wd;
  logic [CW-1:0]   ch_ra, ch_wa;
  logic            ch_we;

  pfm_ram #(.Width(SumW), .Depth(MaxSamples)) u_sum (
    .clk_i, .we_i(sum_we), .waddr_i(sum_wa), .wdata_i(sum_wd),
    .raddr_i(sum_ra), .rdata_o(sum_rd));
  pfm_ram #(.Width(CE), .Depth(NUM_CHANNELS)) u_chan (
    .clk_i, .we_i(ch_we), .waddr_i(ch_wa), .wdata_i(ch_wd),
    .raddr_i(ch_ra), .rdata_o(ch_rd));

  // write-back forwarding: previous stage-1 write
  logic             fw_v_q;
  logic [AW-1:0]    fw_tk_q;
  logic [SumW-1:0]  fw_sum_q;
  logic [CW-1:0]    fw_ch_q;
  logic [CE-1:0]    fw_ce_q;

  logic [SumW-1:0] cur_sum;
  logic [CE-1:0]   cur_ce;
  logic [AdcBits-1:0] cpre, cpro, npre, npro;
  logic chit, nhit;
  logic [TickW-1:0] ctk, ntk;
  logic [SumW:0] ssum;

  always_comb begin
    cur_sum = (fw_v_q && fw_tk_q == tk1_q) ? fw_sum_q : sum_rd;
    cur_ce  = (fw_v_q && fw_ch_q == ch1_q) ? fw_ce_q : ch_rd;
    if (!seen_q[ch1_q] && !(fw_v_q && fw_ch_q == ch1_q))
      cur_ce = {AdcMax, AdcMax, 1'b0, {TickW{1'b0}}};
    {cpre, cpro, chit, ctk} = cur_ce;
    ssum = {1'b0, cur_sum} + {{(SumW+1-AdcBits){1'b0}}, adc1_q};
    npre = (inpre1_q && adc1_q < cpre) ? adc1_q : cpre;
    npro = (inpro1_q && adc1_q < cpro) ? adc1_q : cpro;
    nhit = chit | hit1_q;
    ntk  = (hit1_q && (!chit || tkf1_q < ctk)) ? tkf1_q : ctk;
  end

  // pass registers
  logic [AW:0]        ptr_q;
  logic               rdv_q;
  logic [AW-1:0]      rdt_q;
  logic [CW:0]        cptr_q;
  logic               crdv_q;
  logic [CW-1:0]      crd_q;
  logic [6:0]         hits_q;
  logic [SumW-1:0]    mq_q, mp_q, mk_q;
  logic [AW-1:0]      mkt_q;
  logic signed [47:0] pro_acc_q, pre_acc_q;
  logic [1:0]         mstep_q;
  logic signed [47:0] prod_q;
  logic [119:0]       out_q;

  logic signed [47:0] pe_pro_ch_q, pe_pre_ch_q;

  // per-channel pe is floor per channel; diff*gain exact so floor of each term
  logic signed [16:0] gain_s;
  logic signed [14:0] dpro, dpre;
  logic signed [31:0] tpro, tpre;
  logic [CW-1:0] cidx;
  logic [AdcBits-1:0] rpre, rpro;
  logic rhit;
  logic [TickW-1:0] rtk;
  assign gain_s = $signed({1'b0, gain_q});
  assign cidx = crd_q;
  assign {rpre, rpro, rhit, rtk} = ch_rd;
  assign dpro = $signed({1'b0, base_q}) - $signed({1'b0, rpro});
  assign dpre = $signed({1'b0, base_q}) - $signed({1'b0, rpre});
  assign tpro = dpro * gain_s;
  assign tpre = dpre * gain_s;

  logic [13:0] wendc;
  assign wendc = (wend14 > {1'b0, last_q}) ? {1'b0, last_q} : wend14;

  // flash products, one window minimum per step
  logic [23:0]        fbase;
  logic [SumW-1:0]    fsel;
  logic signed [23:0] fdiff;
  logic signed [40:0] fprod;
  logic signed [47:0] fprod48;
  assign fbase = 24'(base_q * NUM_CHANNELS);
  assign fsel = (mstep_q == 2'd0) ? mq_q : (mstep_q == 2'd1) ? mp_q : mk_q;
  assign fdiff = $signed(fbase) - $signed({3'd0, fsel});
  assign fprod = fdiff * gain_s;
  assign fprod48 = {{7{fprod[40]}}, fprod};

  always_comb begin
    state_d = state_q;
    sum_ra  = in_tk[AW-1:0];
    ch_ra   = in_ch[CW-1:0];
    sum_we  = 1'b0; sum_wa = tk1_q; sum_wd = ssum[SumW] ? SumMax : ssum[SumW-1:0];
    ch_we   = 1'b0; ch_wa = ch1_q; ch_wd = {npre, npro, nhit, ntk};
    unique case (state_q)
      StClr: begin
        sum_we = 1'b1; sum_wa = ptr_q[AW-1:0]; sum_wd = '0;
        if (ptr_q == (AW+1)'(MaxSamples - 1)) state_d = StRun;
      end
      StRun: begin
        if (v1_q) begin
          sum_we = 1'b1; ch_we = 1'b1;
          if (e1_q) state_d = StChan;
        end else if (e1_q) state_d = StChan;
      end
      StChan: begin
        ch_ra = cptr_q[CW-1:0];
        if (cptr_q == (CW+1)'(NUM_CHANNELS) && !crdv_q) state_d = StTick;
      end
      StTick: begin
        sum_ra = ptr_q[AW-1:0];
        if (rdv_q) begin
          sum_we = 1'b1; sum_wa = rdt_q; sum_wd = '0;
        end
        if (ptr_q == (AW+1)'(MaxSamples) && !rdv_q) state_d = StMul;
      end
      StMul: if (mstep_q == 2'd3) state_d = StAcc;
      StAcc: state_d = StOut;
      StOut: if (m_axis_tready) state_d = StRun;
      default: state_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr; ptr_q <= '0; v1_q <= 1'b0; e1_q <= 1'b0; fw_v_q <= 1'b0;
      seen_q <= '0; last_q <= '0; cptr_q <= '0; crdv_q <= 1'b0; rdv_q <= 1'b0;
      mstep_q <= '0;
    end else begin
      state_q <= state_d;
      v1_q <= acc && in_ok;
      e1_q <= acc && s_axis_tlast;
      fw_v_q <= (state_q == StRun) && v1_q;
      unique case (state_q)
        StClr: begin
          ptr_q <= (ptr_q == (AW+1)'(MaxSamples - 1)) ? '0 : ptr_q + 1'b1;
        end
        StRun: begin
          if (v1_q) begin
            seen_q[ch1_q] <= 1'b1;
            if (tk1_q > last_q) last_q <= tk1_q;
          end
          cptr_q <= '0; crdv_q <= 1'b0; ptr_q <= '0; rdv_q <= 1'b0; mstep_q <= '0;
        end
        StChan: begin
          crdv_q <= cptr_q < (CW+1)'(NUM_CHANNELS);
          if (cptr_q < (CW+1)'(NUM_CHANNELS)) cptr_q <= cptr_q + 1'b1;
        end
        StTick: begin
          rdv_q <= ptr_q < (AW+1)'(MaxSamples);
          if (ptr_q < (AW+1)'(MaxSamples)) ptr_q <= ptr_q + 1'b1;
          if (state_d == StMul) seen_q <= '0;
          if (state_d == StMul) last_q <= '0;
        end
        StMul: mstep_q <= mstep_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      tk1_q  <= in_tk[AW-1:0];
      ch1_q  <= in_ch[CW-1:0];
      adc1_q <= in_adc;
      tkf1_q <= in_tk;
      inpre1_q <= {1'b0, in_tk} >= pstart && in_tk < start_q;
      inpro1_q <= in_tk >= start_q && {1'b0, in_tk} < qend14;
      hit1_q   <= in_tk >= start_q && {1'b0, in_tk} < wend14 && in_adc != '0
                  && in_adc < thr_q;
    end
    if (state_q == StRun && v1_q) begin
      fw_tk_q  <= tk1_q;
      fw_sum_q <= sum_wd;
      fw_ch_q  <= ch1_q;
      fw_ce_q  <= ch_wd;
    end
    crd_q <= cptr_q[CW-1:0];
    rdt_q <= ptr_q[AW-1:0];
    unique case (state_q)
      StRun: begin
        hits_q <= '0; pe_pro_ch_q <= '0; pe_pre_ch_q <= '0;
        mq_q <= SumMax; mp_q <= SumMax; mk_q <= SumMax; mkt_q <= '0;
      end
      StChan: if (crdv_q && seen_q[cidx]) begin
        if (rhit && {1'b0, rtk} < wendc) hits_q <= hits_q + 1'b1;
        pe_pro_ch_q <= pe_pro_ch_q + {{28{tpro[31]}}, tpro[31:12]};
        pe_pre_ch_q <= pe_pre_ch_q + {{28{tpre[31]}}, tpre[31:12]};
      end
      StTick: if (rdv_q && rdt_q <= last_q) begin
        if (sum_rd < mk_q) begin mk_q <= sum_rd; mkt_q <= rdt_q; end
        if (rdt_q >= start_q && {1'b0, rdt_q} < qend14 && sum_rd < mq_q)
          mq_q <= sum_rd;
        if ({1'b0, rdt_q} >= pstart && rdt_q < start_q && sum_rd < mp_q)
          mp_q <= sum_rd;
      end
      StMul: begin
        unique case (mstep_q)
          2'd0: prod_q <= fprod48;
          2'd1: begin
            pro_acc_q <= prod_q;
            prod_q <= fprod48;
          end
          2'd2: begin
            pre_acc_q <= prod_q;
            prod_q <= fprod48;
          end
          default: ;
        endcase
      end
      StAcc: begin
        out_q[6:0] <= en_q[0] ? hits_q : 7'd0;
        if (en_q[2]) begin
          out_q[38:7]   <= pe_sat(pro_acc_q);
          out_q[70:39]  <= pe_sat(pre_acc_q);
          out_q[102:71] <= pe_sat(prod_q);
          out_q[116:103] <= 14'({1'b0, mkt_q} - {1'b0, start_q});
        end else begin
          out_q[38:7]   <= en_q[1] ? pe_sat(pe_pro_ch_q <<< 12) : 32'd0;
          out_q[70:39]  <= en_q[1] ? pe_sat(pe_pre_ch_q <<< 12) : 32'd0;
          out_q[102:71] <= '0;
          out_q[116:103] <= '0;
        end
        out_q[117] <= en_q[0];
        out_q[118] <= en_q[1] | en_q[2];
        out_q[119] <= en_q[2];
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = out_q;

endmodule
